[hw/rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: request kinds,
// field widths and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_W   = 15;  // frame number field
  localparam int COUNT_W   = 16;  // region length field
  localparam int TOTAL_W   = 16;  // total_frames register
  localparam int FA_W      = 17;  // frame + length - 1 never exceeds 17 bits
  localparam int WORD_BITS = 32;  // frames per map word
  localparam int OFS_W     = 5;   // bit offset inside a map word

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd32768;

  // Register select bit of the configuration address.
  localparam logic REG_TOTAL_FRAMES = 1'b0;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_RELEASE = 2'd2,
    FN_RESERVE = 2'd3
  } func_t;

  typedef struct packed {
    logic clr_step;   // write one word of the reset sweep
    logic start;      // latch a new request
    logic rd;         // read the map word at the pointer
    logic rd_zero;    // read map word 0
    logic scan_step;  // word was full during allocation, move on
    logic step;       // move to the next word of a region
    logic wr_alloc;   // set the granted bit
    logic wr_clr;     // clear the region bits of the current word
    logic wr_set;     // set the region bits of the current word
    logic wr_fix;     // force frame 0 used
    logic load_out;   // hand the result to the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;    // last word of the reset sweep
    logic room;        // some frame is counted free
    logic scan_end;    // pointer reached the search bound
    logic word_full;   // word read holds no clear bit
    logic region_end;  // no word of the region is left in the map
  } sts_t;

endpackage

[hw/rtl/bfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the allocator. Walks the reset sweep, then for each request
// issues map reads and read-modify-writes until the result is ready.
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  func_t in_func,
  input  logic  out_space,
  input  sts_t  sts,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  func_t  op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= FN_ALLOC;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          op_nxt    = in_func;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (op_r == FN_ALLOC) begin
          if (sts.room && !sts.scan_end) begin
            cmd.rd    = 1'b1;
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (sts.region_end) begin
          state_nxt = (op_r == FN_RELEASE) ? ST_FIX_RD : ST_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        unique case (op_r)
          FN_ALLOC: begin
            if (sts.word_full) begin
              cmd.scan_step = 1'b1;
              state_nxt     = ST_RD;
            end else begin
              cmd.wr_alloc = 1'b1;
              state_nxt    = ST_DONE;
            end
          end
          FN_RESERVE: begin
            cmd.wr_set = 1'b1;
            cmd.step   = 1'b1;
            state_nxt  = ST_RD;
          end
          default: begin
            cmd.wr_clr = 1'b1;
            cmd.step   = 1'b1;
            state_nxt  = ST_RD;
          end
        endcase
      end
      ST_FIX_RD: begin
        cmd.rd_zero = 1'b1;
        state_nxt   = ST_FIX_WR;
      end
      ST_FIX_WR: begin
        cmd.wr_fix = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_space) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/bfa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_datapath
// Used map memory, used frame count, search hint and the word pointer with
// the bit masks and lowest-clear-bit finder that the controller drives.
// ----------------------------------------------------------------------------
module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  func_t              in_func,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [TOTAL_W-1:0] total,
  output sts_t               sts,
  output logic               res_ok,
  output logic [FRAME_W-1:0] res_frame,
  output logic [TOTAL_W-1:0] res_free
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW_W      = $clog2(MAP_WORDS + 1);
  localparam int PTR_W     = (HW_W > FA_W - OFS_W) ? HW_W : FA_W - OFS_W;
  localparam int CNT_W     = ($clog2(NUM_FRAMES + 1) > FA_W) ? $clog2(NUM_FRAMES + 1) : FA_W;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [WA_W-1:0]    clr_ptr_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   hint_r;
  logic [CNT_W-1:0]   used_r;
  logic [FRAME_W-1:0] frame_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               ok_r;
  logic [FRAME_W-1:0] gnt_r;

  logic [CNT_W-1:0]     tot_c;
  logic [CNT_W-1:0]     lim;
  logic [FA_W-1:0]      last;
  logic [PTR_W-1:0]     first_word;
  logic [PTR_W-1:0]     last_word;
  logic [OFS_W-1:0]     lo_bit;
  logic [OFS_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] low;
  logic [OFS_W-1:0]     low_idx;
  logic [WA_W-1:0]      ptr_idx;
  logic                 wr_en;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;

  logic [CNT_W-1:0]   n_start;
  logic [CNT_W:0]     sum_start;
  logic [CNT_W-1:0]   used_start;
  logic [PTR_W-1:0]   in_word;
  logic [COUNT_W-1:0] cnt_start;

  assign tot_c      = CNT_W'(total);
  assign lim        = (tot_c < CNT_W'(NUM_FRAMES)) ? tot_c : CNT_W'(NUM_FRAMES);
  assign last       = FA_W'(frame_r) + FA_W'(cnt_r) - FA_W'(1);
  assign first_word = PTR_W'(frame_r[FRAME_W-1:OFS_W]);
  assign last_word  = PTR_W'(last[FA_W-1:OFS_W]);
  assign ptr_idx    = ptr_r[WA_W-1:0];

  // Region bits of the current word: from the first frame in the first word
  // up to the last frame in the last word.
  assign lo_bit = (ptr_r == first_word) ? frame_r[OFS_W-1:0] : '0;
  assign hi_bit = (ptr_r == last_word) ? last[OFS_W-1:0] : '1;
  assign mask   = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));

  // Lowest clear bit: isolate the lowest set bit of the inverted word.
  assign inv = ~rd_data_r;
  assign low = inv & (~inv + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low[j]) low_idx = low_idx | OFS_W'(j);
    end
  end

  // Status
  assign sts.clr_last   = (clr_ptr_r == WA_W'(MAP_WORDS - 1));
  assign sts.room       = (tot_c > used_r);
  assign sts.scan_end   = (32'(ptr_r) >= 32'(lim >> OFS_W));
  assign sts.word_full  = (rd_data_r == {WORD_BITS{1'b1}});
  assign sts.region_end = (cnt_r == '0) || (ptr_r > last_word) ||
                          (32'(ptr_r) >= 32'(MAP_WORDS));

  // Map memory ports
  assign wr_en = cmd.clr_step | cmd.wr_alloc | cmd.wr_clr | cmd.wr_set | cmd.wr_fix;
  assign rd_en = cmd.rd | cmd.rd_zero;
  assign rd_addr = cmd.rd_zero ? '0 : ptr_idx;

  always_comb begin
    wr_addr = ptr_idx;
    wr_data = rd_data_r;
    if (cmd.clr_step) begin
      wr_addr = clr_ptr_r;
      wr_data = {WORD_BITS{1'b1}};
    end else if (cmd.wr_fix) begin
      wr_addr = '0;
      wr_data = rd_data_r | WORD_BITS'(1);
    end else if (cmd.wr_alloc) begin
      wr_data = rd_data_r | low;
    end else if (cmd.wr_clr) begin
      wr_data = rd_data_r & ~mask;
    end else if (cmd.wr_set) begin
      wr_data = rd_data_r | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= map_mem[rd_addr];
  end

  // Count update of a new request. Every frame of a region moves the count
  // by one with saturation, which folds into one subtract or add and clamp.
  assign cnt_start = (in_func == FN_FREE) ? COUNT_W'(1) : in_count;
  assign n_start   = CNT_W'(cnt_start);
  assign sum_start = {1'b0, used_r} + {1'b0, n_start};
  assign in_word   = PTR_W'(in_frame[FRAME_W-1:OFS_W]);

  always_comb begin
    used_start = used_r;
    unique case (in_func)
      FN_FREE, FN_RELEASE: begin
        used_start = (used_r > n_start) ? (used_r - n_start) : '0;
      end
      FN_RESERVE: begin
        if (used_r < tot_c) begin
          used_start = (sum_start >= {1'b0, tot_c}) ? tot_c : sum_start[CNT_W-1:0];
        end
      end
      default: used_start = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      hint_r    <= '0;
      used_r    <= CNT_W'(NUM_FRAMES);
    end else begin
      if (cmd.clr_step) clr_ptr_r <= clr_ptr_r + WA_W'(1);
      if (cmd.start) begin
        used_r <= used_start;
        // Words below the hint are all full; a freed word may lower it.
        if ((in_func == FN_FREE || (in_func == FN_RELEASE && in_count != '0)) &&
            in_word < hint_r) begin
          hint_r <= in_word;
        end
      end
      if (cmd.scan_step) hint_r <= ptr_r + PTR_W'(1);
      if (cmd.wr_alloc) begin
        hint_r <= ptr_r;
        if (used_r < tot_c) used_r <= used_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      frame_r <= in_frame;
      cnt_r   <= cnt_start;
      ptr_r   <= (in_func == FN_ALLOC) ? hint_r : in_word;
      ok_r    <= (in_func != FN_ALLOC);
      gnt_r   <= '0;
    end else if (cmd.scan_step || cmd.step) begin
      ptr_r <= ptr_r + PTR_W'(1);
    end
    if (cmd.wr_alloc) begin
      ok_r  <= 1'b1;
      gnt_r <= FRAME_W'({ptr_r, low_idx});
    end
  end

  assign res_ok    = ok_r;
  assign res_frame = gnt_r;
  assign res_free  = sts.room ? TOTAL_W'(tot_c - used_r) : '0;

endmodule

[hw/rtl/bitmap_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Page frame allocator over a one-bit-per-frame used map with a used count.
// Grants the lowest free frame, frees frames and releases or reserves runs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                      payload
//  in       slave      in_tvalid / in_tready          tuser: func; tdata: frame, count
//  out      master     out_tvalid / out_tready        tuser: ok; tdata: alloc_frame, free
//  cfg      APB slave  psel, penable, pwrite, pready  register 0: total_frames
//
// Reset sweeps every map word to used, one word per cycle, and no request is
// taken meanwhile. An allocation reads each map word from the search hint on,
// then checks it, until one holds a clear bit, which it sets, the search bound is reached
// or no frame is counted free; a free or a region reads and then rewrites each map word it
// covers, and a release also forces frame 0 used. A finished request stalls only while the
// output register holds an untaken result.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [14:0] frame, [30:15] count, [31] zero
  input  logic [1:0]  in_tuser,    // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [14:0] alloc_frame, [30:15] free_frames, [31] zero
  output logic        out_tuser,   // [0] ok
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t  cmd;
  sts_t  sts;
  func_t in_func;

  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  logic               out_ok_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [TOTAL_W-1:0] out_free_r;
  logic               out_space;
  logic               res_ok;
  logic [FRAME_W-1:0] res_frame;
  logic [TOTAL_W-1:0] res_free;

  assign in_func = func_t'(in_tuser);

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TOTAL_FRAMES) ? {16'd0, total_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_TOTAL_FRAMES) begin
      total_r <= cfg_pwdata[TOTAL_W-1:0];
    end
  end

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_func),
    .out_space (out_space),
    .sts       (sts),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  bfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_func   (in_func),
    .in_frame  (in_tdata[14:0]),
    .in_count  (in_tdata[30:15]),
    .total     (total_r),
    .sts       (sts),
    .res_ok    (res_ok),
    .res_frame (res_frame),
    .res_free  (res_free)
  );

  // Output register
  assign out_space = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r    <= res_ok;
      out_frame_r <= res_frame;
      out_free_r  <= res_free;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {1'b0, out_free_r, out_frame_r};

`ifndef SYNTHESIS
  // A result is never written over one that has not been taken.
  a_load_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded into a full output register");

  // An accepted request makes the block busy and drops in_tready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new beat accepted right after a request");

  // A failed allocation grants no frame.
  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[14:0] == 15'd0))
    else $error("frame reported with a failed allocation");
`endif

endmodule
